### sv/bprt_pkg.sv
// Shared types and constants of the button press relay toggler.
package bprt_pkg;

   // field and register widths
   localparam int TIMER_W     = 16;
   localparam int CNT_W       = 4;
   localparam int IDX_W       = 2;
   localparam int OUT_W       = 3;
   localparam int MAX_BUTTONS = 8;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 16;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_SHORT_LIMIT  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LONG_LIMIT   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_BLINK_PERIOD = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_BLINK_COUNT  = 2'd3;

   // register reset values
   localparam logic [TIMER_W-1:0] SHORT_LIMIT_RST  = 16'd300;
   localparam logic [TIMER_W-1:0] LONG_LIMIT_RST   = 16'd5000;
   localparam logic [TIMER_W-1:0] BLINK_PERIOD_RST = 16'd100;
   localparam logic [CNT_W-1:0]   BLINK_COUNT_RST  = 4'd10;

   localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

   // item codes
   localparam logic OP_TICK     = 1'b0;
   localparam logic OP_LEVEL    = 1'b1;
   localparam logic PIN_PRESSED = 1'b0;

   // what one item asks of a single button
   typedef struct packed {
      logic tick;
      logic press;
      logic release_pin;
   } hold_cmd_type;

   // what one item does to a single button
   typedef struct packed {
      logic held;
      logic short_ev;
      logic long_ev;
      logic expire;
   } hold_stat_type;

   // low bits of a button mask as seen on the result word
   function automatic logic [OUT_W-1:0] fit_out(input logic [MAX_BUTTONS-1:0] m);
      return m[OUT_W-1:0];
   endfunction

endpackage

### sv/bprt_req_if.sv
// Request channel: one tick or one button level change per word.
interface bprt_req_if;
   logic                        valid;
   logic                        ready;
   logic                        opcode;
   logic [bprt_pkg::IDX_W-1:0]  button_index;
   logic                        pin_level;

   modport source (output valid, output opcode, output button_index,
                   output pin_level, input ready);
   modport sink   (input valid, input opcode, input button_index,
                   input pin_level, output ready);
endinterface

### sv/bprt_rsp_if.sv
// Response channel: relay levels and press events, one word per request.
interface bprt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bprt_pkg::OUT_W-1:0]  relay_levels;
   logic [bprt_pkg::OUT_W-1:0]  short_event;
   logic [bprt_pkg::OUT_W-1:0]  long_event;
   logic [bprt_pkg::OUT_W-1:0]  timeout_event;
   logic                        blinking;

   modport source (output valid, output relay_levels, output short_event,
                   output long_event, output timeout_event, output blinking,
                   input ready);
   modport sink   (input valid, input relay_levels, input short_event,
                   input long_event, input timeout_event, input blinking,
                   output ready);
endinterface

### sv/bprt_hold.sv
// Hold timer and press classification of one button.
module bprt_hold (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  bprt_pkg::hold_cmd_type        cmd,
   input  logic [bprt_pkg::TIMER_W-1:0]  short_limit,
   input  logic [bprt_pkg::TIMER_W-1:0]  long_limit,
   output bprt_pkg::hold_stat_type       stat,
   output logic                          held
);

   logic [bprt_pkg::TIMER_W-1:0] timer_ff, timer_in, timer_inc;
   logic                         held_ff, held_in;

   // saturating tick count
   assign timer_inc = (timer_ff != bprt_pkg::TIMER_MAX) ?
                      timer_ff + bprt_pkg::TIMER_W'(1) : timer_ff;

   // next state for the word under way
   always_comb begin
      timer_in = timer_ff;
      held_in  = held_ff;
      stat     = '0;
      priority if (cmd.tick && held_ff) begin
         timer_in = timer_inc;
         if (timer_inc >= long_limit) begin
            held_in     = 1'b0;
            stat.expire = 1'b1;
         end
      end else if (cmd.press) begin
         timer_in = '0;
         held_in  = 1'b1;
      end else if (cmd.release_pin && held_ff) begin
         held_in = 1'b0;
         if (timer_ff < short_limit) begin
            stat.short_ev = 1'b1;
         end else if (timer_ff < long_limit) begin
            stat.long_ev = 1'b1;
         end
      end else begin
         held_in = held_ff;
      end
      stat.held = held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 1'b0;
         timer_ff <= '0;
      end else if (step) begin
         held_ff  <= held_in;
         timer_ff <= timer_in;
      end
   end

   assign held = held_ff;

endmodule

### sv/button_press_relay_toggler_unit.sv
// Top level of the button press relay toggler.
//
// req_ch carries one word per event: a time tick (opcode 0) or a new level of
// one active-low button (opcode 1, button_index, pin_level). Each request
// word yields exactly one word on rsp_ch: the relay levels after it, the
// short and long presses it recognised, the blink mask it started and
// whether a blink run is active.
// The csr_ port writes short_limit, long_limit, blink_period and blink_count
// by index. The user must write it only while no word is in flight; the
// block does not enforce this. A request word passes from the input
// register, which feeds the per-button timers and blink logic in one pass,
// into the response register. One word is accepted every cycle while rsp_ch
// does not stall; the state update of timers and masks sets that rate.
// When rsp_ch stalls, the response register holds its word and the input
// register takes one more word, after which req_ch.ready drops.
// Synchronous reset clears all timers, masks, relays and the pipeline and
// restores the register defaults; the block takes words from the next cycle.
module button_press_relay_toggler_unit #(
   parameter int BUTTONS = 3
) (
   input  logic                             clock,
   input  logic                             reset,
   bprt_req_if.sink                         req_ch,
   bprt_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [bprt_pkg::CSR_ADDR_W-1:0]  csr_index,
   input  logic [bprt_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int WIDE_W = bprt_pkg::MAX_BUTTONS;
   localparam int TW     = bprt_pkg::TIMER_W;
   localparam int CW     = bprt_pkg::CNT_W;

   // configuration registers
   logic [TW-1:0] short_limit_ff, long_limit_ff, blink_period_ff;
   logic [CW-1:0] blink_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_limit_ff  <= bprt_pkg::SHORT_LIMIT_RST;
         long_limit_ff   <= bprt_pkg::LONG_LIMIT_RST;
         blink_period_ff <= bprt_pkg::BLINK_PERIOD_RST;
         blink_count_ff  <= bprt_pkg::BLINK_COUNT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            bprt_pkg::CSR_SHORT_LIMIT:  short_limit_ff  <= csr_wdata;
            bprt_pkg::CSR_LONG_LIMIT:   long_limit_ff   <= csr_wdata;
            bprt_pkg::CSR_BLINK_PERIOD: blink_period_ff <= csr_wdata;
            bprt_pkg::CSR_BLINK_COUNT:  blink_count_ff  <= csr_wdata[CW-1:0];
         endcase
      end
   end

   // input register
   logic                        in_valid_ff;
   logic                        in_opcode_ff;
   logic [bprt_pkg::IDX_W-1:0]  in_index_ff;
   logic                        in_level_ff;
   logic                        out_valid_ff;
   logic                        step;

   assign step         = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_opcode_ff <= req_ch.opcode;
         in_index_ff  <= req_ch.button_index;
         in_level_ff  <= req_ch.pin_level;
      end
   end

   // per-button hold timers
   logic               is_tick;
   logic [BUTTONS-1:0] held_next, held_now, short_vec, long_vec, expire_vec;

   assign is_tick = (in_opcode_ff == bprt_pkg::OP_TICK);

   for (genvar i = 0; i < BUTTONS; i++) begin : g_btn
      bprt_pkg::hold_cmd_type  cmd;
      bprt_pkg::hold_stat_type stat;
      logic                    hit;

      assign hit = (in_opcode_ff == bprt_pkg::OP_LEVEL) && (32'(in_index_ff) == i);
      assign cmd.tick        = is_tick;
      assign cmd.press       = hit && (in_level_ff == bprt_pkg::PIN_PRESSED);
      assign cmd.release_pin = hit && (in_level_ff != bprt_pkg::PIN_PRESSED);

      bprt_hold u_hold (
         .clock       (clock),
         .reset       (reset),
         .step        (step),
         .cmd         (cmd),
         .short_limit (short_limit_ff),
         .long_limit  (long_limit_ff),
         .stat        (stat),
         .held        (held_now[i])
      );

      assign held_next[i]  = stat.held;
      assign short_vec[i]  = stat.short_ev;
      assign long_vec[i]   = stat.long_ev;
      assign expire_vec[i] = stat.expire;
   end

   // blink run and relay state
   logic [BUTTONS-1:0] expired_ff, expired_in;
   logic [BUTTONS-1:0] relay_ff, relay_in;
   logic [BUTTONS-1:0] mask_ff, mask_in;
   logic [BUTTONS-1:0] start_vec;
   logic [TW-1:0]      btimer_ff, btimer_in, btimer_inc;
   logic [CW-1:0]      toggles_ff, toggles_in, toggles_inc;

   assign btimer_inc  = (btimer_ff != bprt_pkg::TIMER_MAX) ?
                        btimer_ff + TW'(1) : btimer_ff;
   assign toggles_inc = toggles_ff + CW'(1);

   always_comb begin
      mask_in    = mask_ff;
      btimer_in  = btimer_ff;
      toggles_in = toggles_ff;
      relay_in   = relay_ff;
      expired_in = expired_ff | expire_vec;
      start_vec  = '0;

      // blink advance on a tick
      if (is_tick && (mask_ff != '0)) begin
         if (btimer_inc >= blink_period_ff) begin
            btimer_in = '0;
            relay_in  = relay_ff ^ mask_ff;
            if (toggles_inc >= blink_count_ff) begin
               mask_in    = '0;
               toggles_in = '0;
            end else begin
               toggles_in = toggles_inc;
            end
         end else begin
            btimer_in = btimer_inc;
         end
      end

      // releases toggle their own relay
      relay_in = relay_in ^ short_vec ^ long_vec;

      // start (or restart) a blink run once nothing is held
      if ((held_next == '0) && (expired_in != '0)) begin
         start_vec  = expired_in;
         mask_in    = expired_in;
         expired_in = '0;
         btimer_in  = '0;
         toggles_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expired_ff <= '0;
         relay_ff   <= '0;
         mask_ff    <= '0;
         btimer_ff  <= '0;
         toggles_ff <= '0;
      end else if (step) begin
         expired_ff <= expired_in;
         relay_ff   <= relay_in;
         mask_ff    <= mask_in;
         btimer_ff  <= btimer_in;
         toggles_ff <= toggles_in;
      end
   end

   // response register
   logic [bprt_pkg::OUT_W-1:0] out_relay_ff, out_short_ff, out_long_ff, out_start_ff;
   logic                       out_blink_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_relay_ff <= bprt_pkg::fit_out(WIDE_W'(relay_in));
         out_short_ff <= bprt_pkg::fit_out(WIDE_W'(short_vec));
         out_long_ff  <= bprt_pkg::fit_out(WIDE_W'(long_vec));
         out_start_ff <= bprt_pkg::fit_out(WIDE_W'(start_vec));
         out_blink_ff <= (mask_in != '0);
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.relay_levels  = out_relay_ff;
   assign rsp_ch.short_event   = out_short_ff;
   assign rsp_ch.long_event    = out_long_ff;
   assign rsp_ch.timeout_event = out_start_ff;
   assign rsp_ch.blinking      = out_blink_ff;

   // checks
   a_expired_needs_held: assert property (@(posedge clock) disable iff (reset)
      (held_now == '0) |-> (expired_ff == '0))
      else $error("expired mask left pending with no button held");

   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_blink_ff == (mask_ff != '0)) &&
                       (out_relay_ff == bprt_pkg::fit_out(WIDE_W'(relay_ff))))
      else $error("response word out of step with relay or blink state");

   a_input_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !step) |=> in_valid_ff)
      else $error("pending request word lost");

   a_events_disjoint: assert property (@(posedge clock) disable iff (reset)
      step |-> ((short_vec & long_vec) == '0) &&
               ($countones(short_vec | long_vec) <= 1))
      else $error("more than one press recognised by one word");

endmodule
